// ----- src/assert_macros.svh -----
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  `ASSERT_CLK(lbl, (ante) |-> (cons), msg)

`endif

// ----- src/tfba_pkg.sv -----
// Package for the tiered fixed block allocator: sizes, codes, types and helpers.
package tfba_pkg;

  localparam int MAX_BLOCKS = 32;
  localparam int NUM_POOLS  = 4;
  localparam int CFG_POOLS  = 4;

  localparam int BLK_W     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int DEPTH_W   = $clog2(MAX_BLOCKS + 1);
  localparam int POOL_W    = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int ADDR_W    = POOL_W + BLK_W;
  localparam int MEM_DEPTH = NUM_POOLS * MAX_BLOCKS;

  localparam int SIZE_W  = 16;
  localparam int CNT_W   = 6;
  localparam int PNUM_W  = 3;
  localparam int IDX_W   = 5;
  localparam int STAT_W  = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int CFG_SIZE_BASE  = 0;
  localparam int CFG_COUNT_BASE = 4;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] SAT_MAX = '1;

  typedef enum logic [2:0] {
    ST_ALLOC   = 3'd0,
    ST_FREED   = 3'd1,
    ST_HEAP    = 3'd2,
    ST_INVALID = 3'd3,
    ST_NOPOOL  = 3'd4
  } status_t;

  typedef struct packed {
    logic              action;
    logic [SIZE_W-1:0] request_size;
    logic [PNUM_W-1:0] free_pool;
    logic [IDX_W-1:0]  free_index;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [PNUM_W-1:0] pool_number;
    logic [IDX_W-1:0]  blk_idx;
    logic              idx_from_mem;
    logic [CNT_W-1:0]  used_blocks;
    logic [CNT_W-1:0]  peak_blocks;
    logic [STAT_W-1:0] fail_count;
    logic [STAT_W-1:0] alloc_total;
    logic [STAT_W-1:0] free_total;
  } res_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BLK_W-1:0]  wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              clr_en;
    logic [POOL_W-1:0] clr_pool;
  } mem_req_t;

  typedef struct packed {
    logic              valid;
    logic [POOL_W-1:0] pool;
  } pend_t;

  function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] v);
    sat_inc = (v == SAT_MAX) ? v : v + STAT_W'(1);
  endfunction

  function automatic logic [DEPTH_W-1:0] pool_blocks(input logic [CNT_W-1:0] c);
    pool_blocks = (int'(c) > MAX_BLOCKS) ? DEPTH_W'(MAX_BLOCKS) : DEPTH_W'(c);
  endfunction

  function automatic logic [SIZE_W-1:0] size_rst(input int p);
    case (p)
      0:       size_rst = SIZE_W'(64);
      1:       size_rst = SIZE_W'(256);
      2:       size_rst = SIZE_W'(1024);
      3:       size_rst = SIZE_W'(4096);
      default: size_rst = '0;
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] count_rst(input int p);
    case (p)
      0:       count_rst = CNT_W'(32);
      1:       count_rst = CNT_W'(16);
      2:       count_rst = CNT_W'(8);
      3:       count_rst = CNT_W'(4);
      default: count_rst = '0;
    endcase
  endfunction

endpackage

// ----- src/tfba_stack_mem.sv -----
// Free-index stack memory for all pools, with per-entry valid bits for reset contents.
module tfba_stack_mem import tfba_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  mem_req_t         mreq,
  output logic [BLK_W-1:0] rd_idx
);

  logic [BLK_W-1:0] mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] valid_r;
  logic [BLK_W-1:0] rd_data_r;
  logic [BLK_W-1:0] rd_dflt_r;
  logic             rd_valid_r;

  always_ff @(posedge clk) begin
    if (mreq.wr_en) begin
      mem[mreq.wr_addr] <= mreq.wr_data;
    end
    if (mreq.rd_en) begin
      rd_data_r <= mem[mreq.rd_addr];
      rd_dflt_r <= mreq.rd_addr[BLK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (mreq.rd_en) begin
        rd_valid_r <= valid_r[mreq.rd_addr];
      end
      if (mreq.clr_en) begin
        for (int k = 0; k < MAX_BLOCKS; k++) begin
          valid_r[{mreq.clr_pool, BLK_W'(k)}] <= 1'b0;
        end
      end else if (mreq.wr_en) begin
        valid_r[mreq.wr_addr] <= 1'b1;
      end
    end
  end

  // an entry never written holds its own slot number
  assign rd_idx = rd_valid_r ? rd_data_r : rd_dflt_r;

endmodule

// ----- src/tfba_pool_ctrl.sv -----
// Pool selection, free checks, per-pool counters and configuration registers.
module tfba_pool_ctrl import tfba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  fire,
  input  req_t                  req,
  input  logic [BLK_W-1:0]      rd_idx,
  output res_t                  res,
  output mem_req_t              mreq
);

  logic [SIZE_W-1:0]     size_r  [NUM_POOLS];
  logic [SIZE_W-1:0]     size_nxt[NUM_POOLS];
  logic [CNT_W-1:0]      count_r  [NUM_POOLS];
  logic [CNT_W-1:0]      count_nxt[NUM_POOLS];
  logic [DEPTH_W-1:0]    depth_r  [NUM_POOLS];
  logic [DEPTH_W-1:0]    depth_nxt[NUM_POOLS];
  logic [MAX_BLOCKS-1:0] map_r  [NUM_POOLS];
  logic [MAX_BLOCKS-1:0] map_nxt[NUM_POOLS];
  logic [MAX_BLOCKS-1:0] map_eff[NUM_POOLS];
  logic [CNT_W-1:0]      peak_r  [NUM_POOLS];
  logic [CNT_W-1:0]      peak_nxt[NUM_POOLS];
  logic [STAT_W-1:0]     fail_r  [NUM_POOLS];
  logic [STAT_W-1:0]     fail_nxt[NUM_POOLS];
  logic [STAT_W-1:0]     alloc_r  [NUM_POOLS];
  logic [STAT_W-1:0]     alloc_nxt[NUM_POOLS];
  logic [STAT_W-1:0]     rel_r  [NUM_POOLS];
  logic [STAT_W-1:0]     rel_nxt[NUM_POOLS];
  pend_t                 pend_r;
  pend_t                 pend_nxt;

  logic [NUM_POOLS-1:0]  fits;
  logic                  found;
  logic [POOL_W-1:0]     sel;
  logic [POOL_W-1:0]     fp;
  logic [DEPTH_W-1:0]    top;
  logic [DEPTH_W-1:0]    used;
  logic                  free_ok;

  always_comb begin
    for (int p = 0; p < NUM_POOLS; p++) begin
      size_nxt[p]  = size_r[p];
      count_nxt[p] = count_r[p];
      depth_nxt[p] = depth_r[p];
      peak_nxt[p]  = peak_r[p];
      fail_nxt[p]  = fail_r[p];
      alloc_nxt[p] = alloc_r[p];
      rel_nxt[p]   = rel_r[p];
      map_eff[p]   = map_r[p];
      fits[p]      = (req.request_size <= size_r[p]);
    end
    // bit set by the previous allocation, whose index has just come out of the stack
    if (pend_r.valid) begin
      map_eff[pend_r.pool][rd_idx] = 1'b1;
    end
    for (int p = 0; p < NUM_POOLS; p++) begin
      map_nxt[p] = map_eff[p];
    end

    res      = '0;
    res.status = ST_HEAP;
    mreq     = '0;
    pend_nxt = '0;
    found    = 1'b0;
    sel      = '0;
    fp       = '0;
    top      = '0;
    used     = '0;
    free_ok  = 1'b0;

    if (fire) begin
      mreq.rd_en = 1'b1;
      if (req.action == ACT_ALLOC) begin
        for (int p = 0; p < NUM_POOLS; p++) begin
          if (!found && fits[p]) begin
            if (depth_r[p] == '0) begin
              fail_nxt[p] = sat_inc(fail_r[p]);
            end else begin
              found = 1'b1;
              sel   = POOL_W'(p);
            end
          end
        end
        if (found) begin
          top            = depth_r[sel] - DEPTH_W'(1);
          depth_nxt[sel] = top;
          mreq.rd_addr   = {sel, top[BLK_W-1:0]};
          used           = pool_blocks(count_r[sel]) - top;
          if (CNT_W'(used) > peak_r[sel]) begin
            peak_nxt[sel] = CNT_W'(used);
          end
          alloc_nxt[sel]   = sat_inc(alloc_r[sel]);
          pend_nxt.valid   = 1'b1;
          pend_nxt.pool    = sel;
          res.status       = ST_ALLOC;
          res.pool_number  = PNUM_W'(sel) + PNUM_W'(1);
          res.idx_from_mem = 1'b1;
          res.used_blocks  = CNT_W'(used);
          res.peak_blocks  = peak_nxt[sel];
          res.fail_count   = fail_nxt[sel];
          res.alloc_total  = alloc_nxt[sel];
          res.free_total   = rel_r[sel];
        end
      end else begin
        if (req.free_pool == '0 || {1'b0, req.free_pool} > (PNUM_W + 1)'(NUM_POOLS)) begin
          res.status = ST_NOPOOL;
        end else begin
          fp      = POOL_W'(req.free_pool - PNUM_W'(1));
          free_ok = (DEPTH_W'(req.free_index) < pool_blocks(count_r[fp])) &&
                    map_eff[fp][BLK_W'(req.free_index)] &&
                    (int'(depth_r[fp]) < MAX_BLOCKS);
          if (free_ok) begin
            map_nxt[fp][BLK_W'(req.free_index)] = 1'b0;
            mreq.wr_en    = 1'b1;
            mreq.wr_addr  = {fp, depth_r[fp][BLK_W-1:0]};
            mreq.wr_data  = BLK_W'(req.free_index);
            depth_nxt[fp] = depth_r[fp] + DEPTH_W'(1);
            rel_nxt[fp]   = sat_inc(rel_r[fp]);
            res.status    = ST_FREED;
          end else begin
            res.status    = ST_INVALID;
          end
          res.pool_number = req.free_pool;
          res.blk_idx     = req.free_index;
          res.used_blocks = CNT_W'(pool_blocks(count_r[fp]) - depth_nxt[fp]);
          res.peak_blocks = peak_r[fp];
          res.fail_count  = fail_r[fp];
          res.alloc_total = alloc_r[fp];
          res.free_total  = rel_nxt[fp];
        end
      end
    end

    if (cfg_wr_en) begin
      for (int p = 0; p < NUM_POOLS; p++) begin
        if (p < CFG_POOLS) begin
          if (cfg_index == CFG_IDX_W'(CFG_SIZE_BASE + p)) begin
            size_nxt[p] = cfg_data;
          end
          if (cfg_index == CFG_IDX_W'(CFG_COUNT_BASE + p)) begin
            count_nxt[p]  = cfg_data[CNT_W-1:0];
            depth_nxt[p]  = pool_blocks(cfg_data[CNT_W-1:0]);
            map_nxt[p]    = '0;
            peak_nxt[p]   = '0;
            fail_nxt[p]   = '0;
            alloc_nxt[p]  = '0;
            rel_nxt[p]    = '0;
            mreq.clr_en   = 1'b1;
            mreq.clr_pool = POOL_W'(p);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_POOLS; p++) begin
        size_r[p]  <= size_rst(p);
        count_r[p] <= count_rst(p);
        depth_r[p] <= pool_blocks(count_rst(p));
        map_r[p]   <= '0;
        peak_r[p]  <= '0;
        fail_r[p]  <= '0;
        alloc_r[p] <= '0;
        rel_r[p]   <= '0;
      end
      pend_r <= '0;
    end else begin
      for (int p = 0; p < NUM_POOLS; p++) begin
        size_r[p]  <= size_nxt[p];
        count_r[p] <= count_nxt[p];
        depth_r[p] <= depth_nxt[p];
        map_r[p]   <= map_nxt[p];
        peak_r[p]  <= peak_nxt[p];
        fail_r[p]  <= fail_nxt[p];
        alloc_r[p] <= alloc_nxt[p];
        rel_r[p]   <= rel_nxt[p];
      end
      pend_r <= pend_nxt;
    end
  end

endmodule

// ----- src/tiered_fixed_block_allocator_core.sv -----
// Top level of the tiered fixed block allocator: request and result registers.
// Four pools of fixed-size blocks serve allocate and free requests. One request is
// accepted per clock; the request register feeds the pool selection and counter
// update, whose outcome is captured in the result register at the same edge that
// reads the free-stack memory for the allocated index. Throughput stays one request
// per cycle as long as results are taken; a stalled result holds the request register
// and stalls the input. Reset brings every pool to a full free stack at once, with no
// clearing pass. The user must make configuration writes only while no request is in
// flight; the block itself does not enforce this.
`include "assert_macros.svh"

module tiered_fixed_block_allocator_core import tfba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_action,
  input  logic [SIZE_W-1:0]     in_request_size,
  input  logic [PNUM_W-1:0]     in_free_pool,
  input  logic [IDX_W-1:0]      in_free_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_status,
  output logic [PNUM_W-1:0]     out_pool_number,
  output logic [IDX_W-1:0]      out_block_index,
  output logic [CNT_W-1:0]      out_used_blocks,
  output logic [CNT_W-1:0]      out_peak_blocks,
  output logic [STAT_W-1:0]     out_fail_count,
  output logic [STAT_W-1:0]     out_alloc_total,
  output logic [STAT_W-1:0]     out_free_total
);

  logic             a_valid_r;
  req_t             a_req_r;
  logic             b_valid_r;
  res_t             b_res_r;
  logic             advance_b;
  logic             fire;
  res_t             res;
  mem_req_t         mreq;
  logic [BLK_W-1:0] rd_idx;

  assign advance_b = !b_valid_r || !out_stall;
  assign fire      = a_valid_r && advance_b;
  assign in_stall  = a_valid_r && !advance_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        a_valid_r <= in_valid;
      end
      if (advance_b) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_req_r <= '{action: in_action, request_size: in_request_size,
                   free_pool: in_free_pool, free_index: in_free_index};
    end
    if (fire) begin
      b_res_r <= res;
    end
  end

  tfba_pool_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .req       (a_req_r),
    .rd_idx    (rd_idx),
    .res       (res),
    .mreq      (mreq)
  );

  tfba_stack_mem u_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .mreq   (mreq),
    .rd_idx (rd_idx)
  );

  assign out_valid       = b_valid_r;
  assign out_status      = b_res_r.status;
  assign out_pool_number = b_res_r.pool_number;
  assign out_block_index = b_res_r.idx_from_mem ? IDX_W'(rd_idx) : b_res_r.blk_idx;
  assign out_used_blocks = b_res_r.used_blocks;
  assign out_peak_blocks = b_res_r.peak_blocks;
  assign out_fail_count  = b_res_r.fail_count;
  assign out_alloc_total = b_res_r.alloc_total;
  assign out_free_total  = b_res_r.free_total;

  `ASSERT_IMPLY(a_stall_cause, in_stall, out_valid && out_stall, "input stall without backpressure")
  `ASSERT_CLK(a_fire_result, fire |=> out_valid, "processed request produced no result")
  `ASSERT_IMPLY(a_peak_bound, out_valid, out_used_blocks <= out_peak_blocks, "used above peak")

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the tiered fixed block allocator: directed and random requests.
module tb_top;
  import tfba_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_PER_PHASE = 95;
  localparam int PHASES = 4;
  localparam int IDLE_PCT = 6;
  localparam int QUIET_LO = 150;
  localparam int QUIET_HI = 270;
  localparam int CYCLE_LIMIT = 100000;

  typedef struct packed {
    status_t           status;
    logic [PNUM_W-1:0] pool;
    logic [IDX_W-1:0]  block;
    logic [CNT_W-1:0]  used;
    logic [CNT_W-1:0]  peak;
    logic [STAT_W-1:0] fails;
    logic [STAT_W-1:0] allocs;
    logic [STAT_W-1:0] frees;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_action = ACT_ALLOC;
  logic [SIZE_W-1:0] in_request_size = '0;
  logic [PNUM_W-1:0] in_free_pool = '0;
  logic [IDX_W-1:0] in_free_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_status;
  logic [PNUM_W-1:0] out_pool_number;
  logic [IDX_W-1:0] out_block_index;
  logic [CNT_W-1:0] out_used_blocks;
  logic [CNT_W-1:0] out_peak_blocks;
  logic [STAT_W-1:0] out_fail_count;
  logic [STAT_W-1:0] out_alloc_total;
  logic [STAT_W-1:0] out_free_total;

  tiered_fixed_block_allocator_core dut (.*);

  always #HALF_PERIOD clk = ~clk;

  // allocator mirror
  logic [SIZE_W-1:0] pool_size [NUM_POOLS];
  logic [CNT_W-1:0] count_cfg [NUM_POOLS];
  logic [IDX_W-1:0] stack_slots [NUM_POOLS][MAX_BLOCKS];
  logic [CNT_W-1:0] free_depth [NUM_POOLS];
  logic [MAX_BLOCKS-1:0] in_use_map [NUM_POOLS];
  logic [CNT_W-1:0] peak_in_use [NUM_POOLS];
  logic [STAT_W-1:0] fail_cnt [NUM_POOLS];
  logic [STAT_W-1:0] alloc_cnt [NUM_POOLS];
  logic [STAT_W-1:0] free_cnt [NUM_POOLS];

  req_t pending_requests[$];
  outcome_t awaited_outcomes[$];
  outcome_t want;
  int accepted = 0;
  int received = 0;
  int mismatches = 0;
  int cycles = 0;
  int n;
  int ph;

  function automatic int usable_blocks(input int p);
    return (int'(count_cfg[p]) > MAX_BLOCKS) ? MAX_BLOCKS : int'(count_cfg[p]);
  endfunction

  function automatic logic [STAT_W-1:0] bump(input logic [STAT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void init_pool(input int p);
    for (int k = 0; k < MAX_BLOCKS; k++) stack_slots[p][k] = IDX_W'(k);
    free_depth[p] = CNT_W'(usable_blocks(p));
    in_use_map[p] = '0;
    peak_in_use[p] = '0;
    fail_cnt[p] = '0;
    alloc_cnt[p] = '0;
    free_cnt[p] = '0;
  endfunction

  function automatic outcome_t snapshot(input int p, input status_t st, input logic [IDX_W-1:0] b);
    outcome_t o;
    o.status = st;
    o.pool = PNUM_W'(p + 1);
    o.block = b;
    o.used = CNT_W'(usable_blocks(p) - int'(free_depth[p]));
    o.peak = peak_in_use[p];
    o.fails = fail_cnt[p];
    o.allocs = alloc_cnt[p];
    o.frees = free_cnt[p];
    return o;
  endfunction

  function automatic outcome_t apply_request(input req_t r);
    outcome_t o;
    int p;
    int top;
    int used;
    logic [IDX_W-1:0] b;
    bit served;
    o = '0;
    served = 1'b0;
    if (r.action == ACT_ALLOC) begin
      o.status = ST_HEAP;
      for (p = 0; p < NUM_POOLS && !served; p++) begin
        if (r.request_size <= pool_size[p]) begin
          if (free_depth[p] == 0) begin
            fail_cnt[p] = bump(fail_cnt[p]);
          end else begin
            top = int'(free_depth[p]) - 1;
            b = stack_slots[p][IDX_W'(top)];
            free_depth[p] = CNT_W'(top);
            in_use_map[p][b] = 1'b1;
            used = usable_blocks(p) - top;
            if (used > int'(peak_in_use[p])) peak_in_use[p] = CNT_W'(used);
            alloc_cnt[p] = bump(alloc_cnt[p]);
            o = snapshot(p, ST_ALLOC, b);
            served = 1'b1;
          end
        end
      end
    end else if (r.free_pool < 1 || r.free_pool > NUM_POOLS) begin
      o.status = ST_NOPOOL;
    end else begin
      p = int'(r.free_pool) - 1;
      b = r.free_index;
      if (int'(b) < usable_blocks(p) && in_use_map[p][b] && free_depth[p] < MAX_BLOCKS) begin
        in_use_map[p][b] = 1'b0;
        stack_slots[p][free_depth[p][IDX_W-1:0]] = b;
        free_depth[p] = free_depth[p] + 1'b1;
        free_cnt[p] = bump(free_cnt[p]);
        o = snapshot(p, ST_FREED, b);
      end else begin
        o = snapshot(p, ST_INVALID, b);
      end
    end
    return o;
  endfunction

  // mostly alloc/free pairs on live blocks, some random noise
  function automatic req_t make_request();
    req_t r;
    int p;
    int q;
    int b;
    int used_total;
    int capacity;
    r.action = 1'($urandom_range(1, 0));
    r.request_size = SIZE_W'($urandom);
    r.free_pool = PNUM_W'($urandom);
    r.free_index = IDX_W'($urandom);
    if ($urandom_range(99, 0) < 15) return r;
    used_total = 0;
    capacity = 0;
    for (p = 0; p < NUM_POOLS; p++) begin
      used_total += $countones(in_use_map[p]);
      capacity += usable_blocks(p);
    end
    if ($urandom_range(99, 0) < ((used_total * 2 > capacity) ? 35 : 65)) begin
      r.action = ACT_ALLOC;
      p = $urandom_range(NUM_POOLS - 1, 0);
      case ($urandom_range(3, 0))
        0: r.request_size = pool_size[p];
        1: r.request_size = pool_size[p] + 1'b1;
        2: r.request_size = SIZE_W'($urandom_range(int'(pool_size[p]), 0));
        default: r.request_size = SIZE_W'($urandom_range(int'(pool_size[p]),
                                                         int'(pool_size[p]) / 2));
      endcase
    end else begin
      r.action = ACT_FREE;
      p = -1;
      b = $urandom_range(NUM_POOLS - 1, 0);
      for (q = 0; q < NUM_POOLS; q++)
        if (p < 0 && in_use_map[(b + q) % NUM_POOLS] != 0) p = (b + q) % NUM_POOLS;
      if (p >= 0) begin
        b = $urandom_range(MAX_BLOCKS - 1, 0);
        while (!in_use_map[p][b]) b = (b + 1) % MAX_BLOCKS;
        r.free_pool = PNUM_W'(p + 1);
        r.free_index = IDX_W'(b);
      end
    end
    return r;
  endfunction

  task automatic queue_alloc(input int sz);
    req_t r;
    r.action = ACT_ALLOC;
    r.request_size = SIZE_W'(sz);
    r.free_pool = '1;
    r.free_index = '1;
    pending_requests.push_back(r);
  endtask

  task automatic queue_free(input int pool, input int b);
    req_t r;
    r.action = ACT_FREE;
    r.request_size = '1;
    r.free_pool = PNUM_W'(pool);
    r.free_index = IDX_W'(b);
    pending_requests.push_back(r);
  endtask

  task automatic write_reg(input int idx, input int val);
    int p;
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data <= CFG_DATA_W'(val);
    if (idx >= CFG_COUNT_BASE) begin
      p = idx - CFG_COUNT_BASE;
      count_cfg[p] = CNT_W'(val);
      init_pool(p);
    end else begin
      pool_size[idx - CFG_SIZE_BASE] = SIZE_W'(val);
    end
  endtask

  task automatic program_phase(input int phase);
    int p;
    for (p = 0; p < CFG_POOLS; p++) begin
      case (phase)
        1: begin
          write_reg(CFG_SIZE_BASE + p, (p == 3) ? 65535 : p + 1);
          write_reg(CFG_COUNT_BASE + p, (p == 0) ? 0 : (p == 1) ? 1 : (p == 2) ? 32 : 63);
        end
        2: begin
          write_reg(CFG_COUNT_BASE + p, $urandom_range(63, 0));
          write_reg(CFG_SIZE_BASE + p, $urandom_range(65535, 1));
        end
        default: begin
          write_reg(CFG_SIZE_BASE + p, 65535);
          write_reg(CFG_COUNT_BASE + p, (p == 0) ? 2 : (p == 1) ? 3 : (p == 2) ? 1 : 5);
        end
      endcase
    end
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_valid || awaited_outcomes.size() != 0)
      @(negedge clk);
  endtask

  task automatic compare_field(input string name, input logic [STAT_W-1:0] exp_v,
                               input logic [STAT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  initial begin
    for (int p = 0; p < NUM_POOLS; p++) begin
      pool_size[p] = (p == 0) ? 64 : (p == 1) ? 256 : (p == 2) ? 1024 : (p == 3) ? 4096 : 0;
      count_cfg[p] = (p == 0) ? 32 : (p == 1) ? 16 : (p == 2) ? 8 : (p == 3) ? 4 : 0;
      init_pool(p);
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    queue_alloc(0);
    queue_alloc(64);
    queue_alloc(65);
    queue_alloc(256);
    queue_alloc(1024);
    queue_alloc(4096);
    queue_alloc(4097);
    queue_alloc(65535);
    queue_free(1, 31);
    queue_free(1, 31);
    queue_free(2, 0);
    queue_free(4, 31);
    queue_free(0, 0);
    queue_free(5, 0);
    queue_free(7, 31);
    repeat (4) queue_alloc(4000);
    queue_free(4, 3);
    queue_alloc(4000);
    queue_free(3, 7);
    queue_alloc(1);

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        wait_drained();
        repeat (4) @(posedge clk);
        program_phase(ph);
      end
      n = 0;
      while (n < RANDOM_PER_PHASE) begin
        @(negedge clk);
        if (pending_requests.size() < 2) begin
          pending_requests.push_back(make_request());
          n++;
        end
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // request driver
  always @(posedge clk) begin
    if (!in_valid || !in_stall) begin
      if (in_valid) begin
        awaited_outcomes.push_back(apply_request({in_action, in_request_size, in_free_pool,
                                                  in_free_index}));
        accepted++;
      end
      if (pending_requests.size() != 0 &&
          ((accepted >= QUIET_LO && accepted < QUIET_HI) ||
           $urandom_range(99, 0) >= IDLE_PCT)) begin
        {in_action, in_request_size, in_free_pool, in_free_index} <= pending_requests.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      received++;
      if (awaited_outcomes.size() == 0) begin
        $error("result with no request outstanding: status %0d", out_status);
        mismatches++;
      end else begin
        want = awaited_outcomes.pop_front();
        compare_field("out_status", STAT_W'(want.status), STAT_W'(out_status));
        compare_field("out_pool_number", STAT_W'(want.pool), STAT_W'(out_pool_number));
        compare_field("out_block_index", STAT_W'(want.block), STAT_W'(out_block_index));
        compare_field("out_used_blocks", STAT_W'(want.used), STAT_W'(out_used_blocks));
        compare_field("out_peak_blocks", STAT_W'(want.peak), STAT_W'(out_peak_blocks));
        compare_field("out_fail_count", want.fails, out_fail_count);
        compare_field("out_alloc_total", want.allocs, out_alloc_total);
        compare_field("out_free_total", want.frees, out_free_total);
      end
    end
    out_stall <= !(received >= QUIET_LO && received < QUIET_HI) &&
                 ($urandom_range(99, 0) < IDLE_PCT);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
